// ===== rtl/breakpoint_interpolation_table_unit_macros.svh =====
// Assertion macros shared by the breakpoint interpolation table unit
`ifndef BREAKPOINT_INTERPOLATION_TABLE_UNIT_MACROS_SVH
`define BREAKPOINT_INTERPOLATION_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPIT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPIT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpit_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the breakpoint interpolation table unit
package bpit_pkg;

  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    MODE_INS_SINGLE = 2'd0,
    MODE_INS_PAIR   = 2'd1,
    MODE_ERASE      = 2'd2,
    MODE_QUERY      = 2'd3
  } mode_t;

  typedef struct packed {
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
  } row_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CHECK,
    ST_DISPATCH,
    ST_INS_MOVE,
    ST_INS_PUT,
    ST_ERA_MOVE,
    ST_ERA_END,
    ST_Q_LO,
    ST_Q_RD_HI,
    ST_Q_HI,
    ST_MUL,
    ST_DIV,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SRCH_RD,
    CMD_SRCH_CMP,
    CMD_IDX_RD,
    CMD_CHECK,
    CMD_RES_LEFT,
    CMD_UPD_RIGHT,
    CMD_INS_PRIME,
    CMD_INS_MOVE,
    CMD_INS_PUT,
    CMD_ERA_PRIME,
    CMD_ERA_MOVE,
    CMD_ERA_END,
    CMD_Q_RD_LO,
    CMD_Q_LO,
    CMD_Q_RD_HI,
    CMD_Q_HI,
    CMD_MUL,
    CMD_DIV_START,
    CMD_RES_DIV,
    CMD_PUSH
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  lo_eq_hi;
    logic  exists;
    logic  count_zero;
    logic  count_full;
    logic  idx_at_count;
    logic  idx_last;
    logic  hq_zero;
    logic  hq_at_end;
    logic  ins_last;
    logic  era_last;
    logic  span_zero;
    logic  div_busy;
  } status_t;

endpackage

// ===== rtl/bpit_ifs.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces
interface bpit_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        position;
  logic signed [31:0] left_value;
  logic signed [31:0] right_value;

  modport source (output valid, output mode, output position, output left_value,
                  output right_value, input ready);
  modport sink (input valid, input mode, input position, input left_value,
                input right_value, output ready);
endinterface

interface bpit_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               key_hit;
  logic               table_full;

  modport source (output valid, output result_value, output key_hit, output table_full,
                  input ready);
  modport sink (input valid, input result_value, input key_hit, input table_full,
                output ready);
endinterface

// ===== rtl/bpit_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider, 64 by 32 bits, quotient known to fit 32 bits
module bpit_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [2*bpit_pkg::VAL_W-1:0] dividend,
  input  logic [bpit_pkg::VAL_W-1:0]   divisor,
  output logic                         busy,
  output logic [bpit_pkg::VAL_W-1:0]   quotient
);

  localparam int W      = bpit_pkg::VAL_W;
  localparam int STEP_W = $clog2(W);

  logic [STEP_W-1:0] step;
  logic [W-1:0]      rem;
  logic [W-1:0]      quo;
  logic [W-1:0]      dvsr;
  logic [W:0]        trial;
  logic [W:0]        diff;
  logic              take;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign take  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // high half of the dividend is below the divisor, so the remainder stays in W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[2*W-1:W];
      quo  <= dividend[W-1:0];
      dvsr <= divisor;
    end else if (busy) begin
      rem <= take ? diff[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/bpit_dp.sv =====
`timescale 1ns / 1ps
// Datapath: breakpoint memory, search and shift pointers, interpolation arithmetic
`include "breakpoint_interpolation_table_unit_macros.svh"
module bpit_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bpit_pkg::cmd_t            cmd,
  output bpit_pkg::status_t         st,
  input  logic [1:0]                in_mode,
  input  logic [31:0]               in_position,
  input  logic signed [31:0]        in_left,
  input  logic signed [31:0]        in_right,
  output logic signed [31:0]        out_value,
  output logic                      out_hit,
  output logic                      out_full
);

  localparam int W  = bpit_pkg::VAL_W;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 1;

  bpit_pkg::row_t  mem [TABLE_DEPTH];
  bpit_pkg::row_t  rd_row;
  bpit_pkg::row_t  cur;
  bpit_pkg::row_t  wr_data;
  bpit_pkg::mode_t mode;

  logic [W-1:0]    pos;
  logic [W-1:0]    new_left;
  logic [W-1:0]    new_right;
  logic [CW-1:0]   count;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   hi;
  logic [CW-1:0]   hq;
  logic [CW-1:0]   ptr;
  logic            exists;
  logic [W-1:0]    first;
  logic [W-1:0]    key_lo;
  logic [W-1:0]    absd;
  logic            neg;
  logic [W-1:0]    t;
  logic [W-1:0]    span;
  logic [2*W-1:0]  mag;
  logic [W-1:0]    res_value;
  logic            res_hit;
  logic            res_full;

  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid;
  logic [CW-1:0]   lo_p1;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   hq_m1;
  logic [CW-1:0]   ptr_m1;
  logic [CW-1:0]   ptr_m2;
  logic [CW-1:0]   ptr_p2;
  logic            ex_now;
  logic [W:0]      d33;
  logic [W:0]      absd33;
  logic [2*W-1:0]  prod;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic            div_start;
  logic            div_busy;
  logic [W-1:0]    quo;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign lo_p1   = lo + CW'(1);
  assign cnt_m1  = count - CW'(1);
  assign hq_m1   = hq - CW'(1);
  assign ptr_m1  = ptr - CW'(1);
  assign ptr_m2  = ptr - CW'(2);
  assign ptr_p2  = ptr + CW'(2);
  assign ex_now  = (lo < count) && (rd_row.key == pos);

  assign d33    = {rd_row.left[W-1], rd_row.left} - {first[W-1], first};
  assign absd33 = d33[W] ? ((W+1)'(0) - d33) : d33;
  assign prod   = absd * t;

  assign div_start = (cmd == bpit_pkg::CMD_DIV_START);

  bpit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (span),
    .busy     (div_busy),
    .quotient (quo)
  );

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_row;
    unique case (cmd)
      bpit_pkg::CMD_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid[IW-1:0];
      end
      bpit_pkg::CMD_IDX_RD: begin
        rd_en   = 1'b1;
        rd_addr = lo[IW-1:0];
      end
      bpit_pkg::CMD_INS_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[IW-1:0];
      end
      bpit_pkg::CMD_INS_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = ptr[IW-1:0];
        rd_en   = 1'b1;
        rd_addr = ptr_m2[IW-1:0];
      end
      bpit_pkg::CMD_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = lo[IW-1:0];
        wr_data = '{key: pos, left: new_left,
                    right: (mode == bpit_pkg::MODE_INS_SINGLE) ? new_left : new_right};
      end
      bpit_pkg::CMD_UPD_RIGHT: begin
        wr_en   = 1'b1;
        wr_addr = lo[IW-1:0];
        wr_data = '{key: cur.key, left: cur.left, right: new_left};
      end
      bpit_pkg::CMD_ERA_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = lo_p1[IW-1:0];
      end
      bpit_pkg::CMD_ERA_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = ptr[IW-1:0];
        rd_en   = 1'b1;
        rd_addr = ptr_p2[IW-1:0];
      end
      bpit_pkg::CMD_Q_RD_LO: begin
        rd_en   = 1'b1;
        rd_addr = hq_m1[IW-1:0];
      end
      bpit_pkg::CMD_Q_RD_HI: begin
        rd_en   = 1'b1;
        rd_addr = hq[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd == bpit_pkg::CMD_INS_PUT) begin
      count <= count + CW'(1);
    end else if (cmd == bpit_pkg::CMD_ERA_END) begin
      count <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      bpit_pkg::CMD_LOAD: begin
        mode      <= bpit_pkg::mode_t'(in_mode);
        pos       <= in_position;
        new_left  <= in_left;
        new_right <= in_right;
        lo        <= '0;
        hi        <= count;
        res_value <= '0;
        res_hit   <= 1'b0;
        res_full  <= 1'b0;
      end
      bpit_pkg::CMD_SRCH_CMP: begin
        if (rd_row.key < pos) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      bpit_pkg::CMD_CHECK: begin
        exists   <= ex_now;
        cur      <= rd_row;
        hq       <= ex_now ? lo_p1 : lo;
        res_hit  <= ex_now && (mode != bpit_pkg::MODE_QUERY);
        res_full <= !ex_now && (count == CW'(TABLE_DEPTH)) &&
                    (mode == bpit_pkg::MODE_INS_SINGLE || mode == bpit_pkg::MODE_INS_PAIR);
      end
      bpit_pkg::CMD_RES_LEFT: res_value <= cur.left;
      bpit_pkg::CMD_INS_PRIME: ptr <= count;
      bpit_pkg::CMD_INS_MOVE: ptr <= ptr_m1;
      bpit_pkg::CMD_ERA_PRIME: ptr <= lo;
      bpit_pkg::CMD_ERA_MOVE: ptr <= ptr + CW'(1);
      bpit_pkg::CMD_Q_LO: begin
        first     <= rd_row.right;
        key_lo    <= rd_row.key;
        res_value <= rd_row.right;
      end
      bpit_pkg::CMD_Q_HI: begin
        absd <= absd33[W-1:0];
        neg  <= d33[W];
        t    <= pos - key_lo;
        span <= rd_row.key - key_lo;
      end
      bpit_pkg::CMD_MUL: mag <= prod;
      bpit_pkg::CMD_RES_DIV: res_value <= neg ? (first - quo) : (first + quo);
      bpit_pkg::CMD_PUSH: begin
        out_value <= res_value;
        out_hit   <= res_hit;
        out_full  <= res_full;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st.mode         = mode;
    st.lo_eq_hi     = (lo == hi);
    st.exists       = exists;
    st.count_zero   = (count == '0);
    st.count_full   = (count == CW'(TABLE_DEPTH));
    st.idx_at_count = (lo == count);
    st.idx_last     = (lo_p1 == count);
    st.hq_zero      = (hq == '0);
    st.hq_at_end    = (hq >= count);
    st.ins_last     = (ptr_m1 == lo);
    st.era_last     = (ptr_p2 == count);
    st.span_zero    = (span == '0);
    st.div_busy     = div_busy;
  end

  `BPIT_ASSERT_IMP(a_put_room, clk, rst, cmd == bpit_pkg::CMD_INS_PUT, count < CW'(TABLE_DEPTH), "insert with table full")
  `BPIT_ASSERT_IMP(a_era_nonempty, clk, rst, cmd == bpit_pkg::CMD_ERA_END, count != '0, "erase from empty table")

endmodule

// ===== rtl/bpit_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences search, shift, query and divide steps for one transaction
`include "breakpoint_interpolation_table_unit_macros.svh"
module bpit_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bpit_pkg::cmd_t    cmd,
  input  bpit_pkg::status_t st
);

  bpit_pkg::state_t state;
  bpit_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpit_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = bpit_pkg::CMD_NONE;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      bpit_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = bpit_pkg::CMD_LOAD;
          state_next = bpit_pkg::ST_SRCH_RD;
        end
      end
      bpit_pkg::ST_SRCH_RD: begin
        if (st.lo_eq_hi) begin
          cmd        = bpit_pkg::CMD_IDX_RD;
          state_next = bpit_pkg::ST_CHECK;
        end else begin
          cmd        = bpit_pkg::CMD_SRCH_RD;
          state_next = bpit_pkg::ST_SRCH_CMP;
        end
      end
      bpit_pkg::ST_SRCH_CMP: begin
        cmd        = bpit_pkg::CMD_SRCH_CMP;
        state_next = bpit_pkg::ST_SRCH_RD;
      end
      bpit_pkg::ST_CHECK: begin
        cmd        = bpit_pkg::CMD_CHECK;
        state_next = bpit_pkg::ST_DISPATCH;
      end
      bpit_pkg::ST_DISPATCH: begin
        priority if (st.mode == bpit_pkg::MODE_QUERY) begin
          if (st.count_zero) begin
            state_next = bpit_pkg::ST_DONE;
          end else if (st.hq_zero) begin
            cmd        = bpit_pkg::CMD_RES_LEFT;
            state_next = bpit_pkg::ST_DONE;
          end else begin
            cmd        = bpit_pkg::CMD_Q_RD_LO;
            state_next = bpit_pkg::ST_Q_LO;
          end
        end else if (st.mode == bpit_pkg::MODE_ERASE) begin
          if (!st.exists) begin
            state_next = bpit_pkg::ST_DONE;
          end else if (st.idx_last) begin
            state_next = bpit_pkg::ST_ERA_END;
          end else begin
            cmd        = bpit_pkg::CMD_ERA_PRIME;
            state_next = bpit_pkg::ST_ERA_MOVE;
          end
        end else begin
          if (st.exists) begin
            if (st.mode == bpit_pkg::MODE_INS_SINGLE) begin
              cmd = bpit_pkg::CMD_UPD_RIGHT;
            end
            state_next = bpit_pkg::ST_DONE;
          end else if (st.count_full) begin
            state_next = bpit_pkg::ST_DONE;
          end else if (st.idx_at_count) begin
            state_next = bpit_pkg::ST_INS_PUT;
          end else begin
            cmd        = bpit_pkg::CMD_INS_PRIME;
            state_next = bpit_pkg::ST_INS_MOVE;
          end
        end
      end
      bpit_pkg::ST_INS_MOVE: begin
        cmd = bpit_pkg::CMD_INS_MOVE;
        if (st.ins_last) begin
          state_next = bpit_pkg::ST_INS_PUT;
        end
      end
      bpit_pkg::ST_INS_PUT: begin
        cmd        = bpit_pkg::CMD_INS_PUT;
        state_next = bpit_pkg::ST_DONE;
      end
      bpit_pkg::ST_ERA_MOVE: begin
        cmd = bpit_pkg::CMD_ERA_MOVE;
        if (st.era_last) begin
          state_next = bpit_pkg::ST_ERA_END;
        end
      end
      bpit_pkg::ST_ERA_END: begin
        cmd        = bpit_pkg::CMD_ERA_END;
        state_next = bpit_pkg::ST_DONE;
      end
      bpit_pkg::ST_Q_LO: begin
        cmd = bpit_pkg::CMD_Q_LO;
        // at or past the last key the lower point's right value is the answer
        state_next = st.hq_at_end ? bpit_pkg::ST_DONE : bpit_pkg::ST_Q_RD_HI;
      end
      bpit_pkg::ST_Q_RD_HI: begin
        cmd        = bpit_pkg::CMD_Q_RD_HI;
        state_next = bpit_pkg::ST_Q_HI;
      end
      bpit_pkg::ST_Q_HI: begin
        cmd        = bpit_pkg::CMD_Q_HI;
        state_next = bpit_pkg::ST_MUL;
      end
      bpit_pkg::ST_MUL: begin
        cmd        = bpit_pkg::CMD_MUL;
        state_next = st.span_zero ? bpit_pkg::ST_DONE : bpit_pkg::ST_DIV;
      end
      bpit_pkg::ST_DIV: begin
        cmd        = bpit_pkg::CMD_DIV_START;
        state_next = bpit_pkg::ST_DIV_WAIT;
      end
      bpit_pkg::ST_DIV_WAIT: begin
        if (!st.div_busy) begin
          cmd        = bpit_pkg::CMD_RES_DIV;
          state_next = bpit_pkg::ST_DONE;
        end
      end
      bpit_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd            = bpit_pkg::CMD_PUSH;
          out_valid_next = 1'b1;
          state_next     = bpit_pkg::ST_IDLE;
        end
      end
      default: state_next = bpit_pkg::ST_IDLE;
    endcase
  end

  `BPIT_ASSERT_IMP(a_push_free, clk, rst, cmd == bpit_pkg::CMD_PUSH, !out_valid || out_ready, "result register overwritten")
  `BPIT_ASSERT_NXT(a_div_runs, clk, rst, state == bpit_pkg::ST_DIV, st.div_busy, "divider did not start")

endmodule

// ===== rtl/breakpoint_interpolation_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the breakpoint interpolation table unit
//
//   channel  dir  payload
//   req      in   mode, position, left_value, right_value
//   rsp      out  result_value, key_hit, table_full
//
// One transaction at a time; req.ready is high only while the controller is idle.
// Insert/erase: a binary search, then the entries are shifted in memory, one entry per cycle.
// Query: a binary search, then interpolation through the 32-step restoring divider.
// Reset (rst, synchronous) empties the table at once; entry contents are not cleared.
// A finished result sits in the rsp register while the next request is taken;
// a stalled rsp holds the controller only when the following result is ready.
module breakpoint_interpolation_table_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  bpit_req_if.sink   req,
  bpit_rsp_if.source rsp
);

  bpit_pkg::cmd_t    cmd;
  bpit_pkg::status_t st;

  bpit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .st        (st)
  );

  bpit_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_mode     (req.mode),
    .in_position (req.position),
    .in_left     (req.left_value),
    .in_right    (req.right_value),
    .out_value   (rsp.result_value),
    .out_hit     (rsp.key_hit),
    .out_full    (rsp.table_full)
  );

endmodule
